// ===== hdl/nfasa_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and helper functions for the NFA string acceptor.
// Used by the channel interfaces, the transition cell and the top level.
package nfasa_pkg;

   // Automaton size.
   localparam int NUM_STATES      = 16;
   localparam int NUM_TRANSITIONS = 64;

   // Field widths of the words on the channels and registers.
   localparam int OP_W          = 2;
   localparam int STATE_FIELD_W = 4;
   localparam int LABEL_W       = 8;
   localparam int MASK_W        = 16;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 16;

   // Derived widths.
   localparam int STATE_IDX_W = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
   localparam int COUNT_W     = $clog2(NUM_TRANSITIONS + 1);
   localparam int ROUND_W     = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;

   // Operation codes of a request word.
   localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OP_W-1:0] OP_BEGIN = 2'd1;
   localparam logic [OP_W-1:0] OP_FEED  = 2'd2;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_START_STATE    = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACCEPTING_MASK = 1'd1;

   // The label that marks a lambda move.
   localparam logic [LABEL_W-1:0] LAMBDA_LABEL = 8'h00;

   // One stored transition.
   typedef struct packed {
      logic                     valid;
      logic [STATE_FIELD_W-1:0] src;
      logic [LABEL_W-1:0]       lbl;
      logic [STATE_FIELD_W-1:0] dst;
   } entry_type;

   // Table control that the sequencer hands to every cell.
   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctrl_type;

   typedef logic [NUM_STATES-1:0] state_set_type;

   // One-hot set bit for a state, empty when the index names no state.
   function automatic state_set_type state_bit(input logic [STATE_FIELD_W-1:0] s);
      state_set_type one;
      one = state_set_type'(1);
      if (s < NUM_STATES) begin
         return one << STATE_IDX_W'(s);
      end
      return '0;
   endfunction

   // Accepting states as a set; states past the mask are never accepting.
   function automatic state_set_type accept_set(input logic [MASK_W-1:0] mask);
      return state_set_type'({{NUM_STATES{1'b0}}, mask});
   endfunction

endpackage

// ===== hdl/nfasa_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and response words.
// Depends on nfasa_pkg for the field widths.
interface nfasa_req_if;
   import nfasa_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          op;
   logic [STATE_FIELD_W-1:0] source_state;
   logic [STATE_FIELD_W-1:0] target_state;
   logic [LABEL_W-1:0]       edge_label;
   logic [LABEL_W-1:0]       symbol;

   modport source (output valid, op, source_state, target_state, edge_label, symbol,
                   input ready);
   modport sink   (input valid, op, source_state, target_state, edge_label, symbol,
                   output ready);
endinterface

interface nfasa_rsp_if;
   logic valid;
   logic ready;
   logic accepted;
   logic dead;
   logic table_full;

   modport source (output valid, accepted, dead, table_full, input ready);
   modport sink   (input valid, accepted, dead, table_full, output ready);
endinterface

// ===== hdl/nfa_string_acceptor.sv =====
`timescale 1ns / 1ps
// Top level of the NFA string acceptor: sequencer, active set, row of
// transition cells and response register. Depends on nfasa_pkg, nfasa_if, nfasa_cell.
//
//   Channel   Direction  Protocol     Word
//   req_port  in         valid/ready  op, source_state, target_state, edge_label, symbol
//   rsp_port  out        valid/ready  accepted, dead, table_full
//   csr_*     in         write only   start_state (0), accepting_mask (1)
//
// Load, clear and a feed of symbol zero go straight to the finish state; begin runs the
// lambda closure, and any other feed moves on its symbol and then runs the closure.
// Each closure round is one pass of the active set over the whole cell row.
// Reset is synchronous: it empties the table, the active set and the registers.
// A new word is taken while the previous response still waits; a finished
// response holds the sequencer only while the response register is full and not taken.
module nfa_string_acceptor (
   input  logic clock,
   input  logic reset,
   nfasa_req_if.sink   req_port,
   nfasa_rsp_if.source rsp_port,
   input  logic                                csr_write_en,
   input  logic [nfasa_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [nfasa_pkg::CSR_DATA_W-1:0]    csr_data
);
   import nfasa_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_MOVE   = 2'd1;
   localparam logic [1:0] ST_CLOS   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]               state_ff, state_in;
   state_set_type            set_ff, set_in;
   logic [LABEL_W-1:0]       label_ff, label_in;
   logic [ROUND_W-1:0]       round_ff, round_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic                     refused_ff, refused_in;
   logic [STATE_FIELD_W-1:0] start_ff;
   logic [MASK_W-1:0]        mask_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_accepted_ff, rsp_dead_ff, rsp_full_ff;

   logic          accept;
   logic          table_full_now;
   logic          finish;
   cell_ctrl_type ctrl;
   entry_type     new_entry;
   entry_type     cell_entry [NUM_TRANSITIONS];
   state_set_type cell_fire  [NUM_TRANSITIONS];
   state_set_type fire_all;
   state_set_type grown;
   logic [LABEL_W-1:0] bcast_label;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         mask_ff  <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_START_STATE:    start_ff <= csr_data[STATE_FIELD_W-1:0];
            CSR_ACCEPTING_MASK: mask_ff  <= csr_data[MASK_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_port.ready = (state_ff == ST_IDLE);
   assign accept         = req_port.valid && req_port.ready;
   assign table_full_now = (count_ff == COUNT_W'(NUM_TRANSITIONS));
   assign finish         = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_port.ready);

   // Table control: a load shifts a new entry into the head of the row unless it is full.
   assign ctrl.shift = accept && (req_port.op == OP_LOAD) && !table_full_now;
   assign ctrl.clear = accept && (req_port.op == OP_CLEAR);
   assign new_entry  = '{valid: 1'b1, src: req_port.source_state,
                         lbl: req_port.edge_label, dst: req_port.target_state};

   assign bcast_label = (state_ff == ST_MOVE) ? label_ff : LAMBDA_LABEL;

   // The row of transition cells.
   for (genvar i = 0; i < NUM_TRANSITIONS; i++) begin : g_cell
      if (i == 0) begin : g_head
         nfasa_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .prev_entry (new_entry),
            .entry      (cell_entry[i]),
            .cur_set    (set_ff),
            .cur_label  (bcast_label),
            .fire_set   (cell_fire[i])
         );
      end else begin : g_body
         nfasa_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .prev_entry (cell_entry[i-1]),
            .entry      (cell_entry[i]),
            .cur_set    (set_ff),
            .cur_label  (bcast_label),
            .fire_set   (cell_fire[i])
         );
      end
   end

   // Union of the states reached by every firing cell.
   always_comb begin
      fire_all = '0;
      for (int i = 0; i < NUM_TRANSITIONS; i++) begin
         fire_all = fire_all | cell_fire[i];
      end
   end

   assign grown = set_ff | fire_all;

   // Sequencer.
   always_comb begin
      state_in   = state_ff;
      set_in     = set_ff;
      label_in   = label_ff;
      round_in   = round_ff;
      count_in   = count_ff;
      refused_in = refused_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               refused_in = 1'b0;
               state_in   = ST_FINISH;
               round_in   = '0;
               unique case (req_port.op)
                  OP_LOAD: begin
                     if (table_full_now) begin
                        refused_in = 1'b1;
                     end else begin
                        count_in = count_ff + COUNT_W'(1);
                     end
                  end
                  OP_BEGIN: begin
                     set_in   = state_bit(start_ff);
                     state_in = ST_CLOS;
                  end
                  OP_FEED: begin
                     if (req_port.symbol == LAMBDA_LABEL) begin
                        set_in = '0;
                     end else begin
                        label_in = req_port.symbol;
                        state_in = ST_MOVE;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_MOVE: begin
            set_in   = fire_all;
            state_in = ST_CLOS;
         end
         ST_CLOS: begin
            set_in   = grown;
            round_in = round_ff + ROUND_W'(1);
            if ((grown == set_ff) || (round_ff == ROUND_W'(NUM_STATES - 1))) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         set_ff     <= '0;
         count_ff   <= '0;
         round_ff   <= '0;
         refused_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         set_ff     <= set_in;
         count_ff   <= count_in;
         round_ff   <= round_in;
         refused_ff <= refused_in;
      end
   end

   always_ff @(posedge clock) begin
      label_ff <= label_in;
   end

   // Response register: loaded when a word finishes, emptied when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_accepted_ff <= |(set_ff & accept_set(mask_ff));
         rsp_dead_ff     <= (set_ff == '0);
         rsp_full_ff     <= refused_ff;
      end
   end

   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.accepted   = rsp_accepted_ff;
   assign rsp_port.dead       = rsp_dead_ff;
   assign rsp_port.table_full = rsp_full_ff;

   // The entry count never passes the size of the row.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(NUM_TRANSITIONS))
      else $error("entry count beyond table size");

   // The closure only ever adds states to the active set.
   a_closure_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLOS) |=> ((set_ff & $past(set_ff)) == $past(set_ff)))
      else $error("closure round dropped a state");

   // A refused load is only reported when the row is full.
   a_refused_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && refused_ff) |-> table_full_now)
      else $error("load refused with room in the table");

   // A finished word always lands in the response register.
   a_finish_loads: assert property (@(posedge clock) disable iff (reset)
      finish |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished word not presented");

endmodule

// ===== hdl/nfasa_cell.sv =====
`timescale 1ns / 1ps
// One cell of the transition row: holds a single transition, passes it on to
// its neighbor when the row shifts, and reports the states it fires into.
// Depends on nfasa_pkg.
module nfasa_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  nfasa_pkg::cell_ctrl_type ctrl,
   input  nfasa_pkg::entry_type    prev_entry,
   output nfasa_pkg::entry_type    entry,
   input  nfasa_pkg::state_set_type cur_set,
   input  logic [nfasa_pkg::LABEL_W-1:0] cur_label,
   output nfasa_pkg::state_set_type fire_set
);
   import nfasa_pkg::*;

   logic                     valid_ff;
   logic                     valid_in;
   logic [STATE_FIELD_W-1:0] src_ff;
   logic [LABEL_W-1:0]       lbl_ff;
   logic [STATE_FIELD_W-1:0] dst_ff;
   logic                     hit;

   // A clear drops the entry; a shift takes the neighbor's entry.
   always_comb begin
      valid_in = valid_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.shift) begin
         valid_in = prev_entry.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Transition fields carry no reset; the valid bit guards them.
   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         src_ff <= prev_entry.src;
         lbl_ff <= prev_entry.lbl;
         dst_ff <= prev_entry.dst;
      end
   end

   assign entry = '{valid: valid_ff, src: src_ff, lbl: lbl_ff, dst: dst_ff};

   // The transition fires when its label matches and its source is active.
   assign hit      = valid_ff && (lbl_ff == cur_label) && (|(cur_set & state_bit(src_ff)));
   assign fire_set = hit ? state_bit(dst_ff) : '0;

endmodule
